### design/vau_pkg.sv
// ----------------------------------------------------------------------------
// Vector arithmetic unit package
// Command codes, pipeline payload types and the per-stage step functions of
// the square root and divider pipelines.
// ----------------------------------------------------------------------------
package vau_pkg;

  // Command codes.
  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_SUB   = 3'd1;
  localparam logic [2:0] CMD_DOT   = 3'd2;
  localparam logic [2:0] CMD_CROSS = 3'd3;
  localparam logic [2:0] CMD_SCALE = 3'd4;
  localparam logic [2:0] CMD_LEN   = 3'd5;
  localparam logic [2:0] CMD_NORM  = 3'd6;

  // Square root pipeline: 32 root bits, four per stage.
  localparam int SQ_STEPS  = 4;
  localparam int SQ_STAGES = 8;

  // Divider pipeline: 20 quotient bits, four per stage.
  localparam int DV_STEPS  = 4;
  localparam int DV_STAGES = 5;
  localparam int QW        = DV_STEPS * DV_STAGES;

  // Results that are settled ahead of the root, carried down the pipe.
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [63:0] scalar;
    logic               sat;
  } side_t;

  // Square root working state.
  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] opnd;
  } sq_t;

  // Divider working state for one component.
  typedef struct packed {
    logic [31:0]   rem;
    logic [QW-1:0] bits;
    logic [QW-1:0] quo;
  } dv_t;

  // Clamp a wide signed value to 32 bits; the top bit flags a clamp.
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (v < -66'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end else begin
      return {1'b0, v[31:0]};
    end
  endfunction

  // Four digit-by-digit square root steps, two operand bits each.
  function automatic sq_t sqrt_stage(input sq_t s);
    sq_t         t;
    logic [34:0] rem2;
    logic [34:0] trial;
    t = s;
    for (int k = 0; k < SQ_STEPS; k++) begin
      rem2  = {t.rem[32:0], t.opnd[63:62]};
      trial = {1'b0, t.root, 2'b01};
      if (rem2 >= trial) begin
        t.rem  = 34'(rem2 - trial);
        t.root = {t.root[30:0], 1'b1};
      end else begin
        t.rem  = rem2[33:0];
        t.root = {t.root[30:0], 1'b0};
      end
      t.opnd = {t.opnd[61:0], 2'b00};
    end
    return t;
  endfunction

  // Four restoring division steps, one quotient bit each.
  function automatic dv_t div_stage(input dv_t s, input logic [31:0] d);
    dv_t         t;
    logic [32:0] r2;
    t = s;
    for (int k = 0; k < DV_STEPS; k++) begin
      r2 = {t.rem, t.bits[QW-1]};
      if (r2 >= {1'b0, d}) begin
        t.rem = 32'(r2 - {1'b0, d});
        t.quo = {t.quo[QW-2:0], 1'b1};
      end else begin
        t.rem = r2[31:0];
        t.quo = {t.quo[QW-2:0], 1'b0};
      end
      t.bits = {t.bits[QW-2:0], 1'b0};
    end
    return t;
  endfunction

endpackage

### design/vector3_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit
// Add, subtract, dot, cross, scale, length and normalize on Q16.16 vectors.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// busy stays low: the unit is fully pipelined and takes one request every
// cycle. Each request gives one result, shown on rx, ry, rz, scalar_out,
// saturated and zero_vector for exactly one cycle while done is high.
// The stages are input capture, the shared multiplier bank, the combine
// stage, eight square root stages (four root bits each), five divider
// stages (four quotient bits each) and the output register. Every command
// runs through the full pipe so results keep order. The receiver cannot
// stall the unit, so there is no backpressure path.
// Reset clears all valid bits; no result is shown until new requests arrive.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] az,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  logic signed [31:0] bz,
  input  logic signed [31:0] factor,
  output logic               done,
  output logic signed [31:0] rx,
  output logic signed [31:0] ry,
  output logic signed [31:0] rz,
  output logic signed [63:0] scalar_out,
  output logic               saturated,
  output logic               zero_vector
);

  logic                   fr_valid;
  vau_pkg::side_t         fr_side;
  logic [63:0]            fr_sumsq;
  logic                   sq_valid;
  logic [31:0]            sq_root;
  vau_pkg::side_t         sq_side;
  logic                   dv_valid;
  logic [31:0]            dv_root;
  logic [vau_pkg::QW-1:0] dv_quo [3];
  vau_pkg::side_t         dv_side;

  logic signed [31:0]     nq [3];
  logic signed [31:0]     rx_next;
  logic signed [31:0]     ry_next;
  logic signed [31:0]     rz_next;
  logic signed [63:0]     scalar_next;
  logic                   sat_next;
  logic                   zero_next;

  assign busy = 1'b0;

  vau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .cmd       (cmd),
    .ax        (ax),
    .ay        (ay),
    .az        (az),
    .bx        (bx),
    .by        (by),
    .bz        (bz),
    .factor    (factor),
    .out_valid (fr_valid),
    .side      (fr_side),
    .sumsq     (fr_sumsq)
  );

  vau_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .sumsq     (fr_sumsq),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  vau_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_root  (dv_root),
    .quo       (dv_quo),
    .out_side  (dv_side)
  );

  // Signed normalized components; the quotient never needs clamping.
  always_comb begin
    nq[0] = dv_side.ax[31] ? -32'(dv_quo[0]) : 32'(dv_quo[0]);
    nq[1] = dv_side.ay[31] ? -32'(dv_quo[1]) : 32'(dv_quo[1]);
    nq[2] = dv_side.az[31] ? -32'(dv_quo[2]) : 32'(dv_quo[2]);
  end

  // Final result selection.
  always_comb begin
    rx_next     = dv_side.rx;
    ry_next     = dv_side.ry;
    rz_next     = dv_side.rz;
    scalar_next = dv_side.scalar;
    sat_next    = dv_side.sat;
    zero_next   = 1'b0;
    case (dv_side.cmd)
      vau_pkg::CMD_LEN: begin
        scalar_next = 64'(dv_root);
      end
      vau_pkg::CMD_NORM: begin
        if (dv_root == 32'd0) begin
          zero_next = 1'b1;
        end else begin
          rx_next = nq[0];
          ry_next = nq[1];
          rz_next = nq[2];
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
    rx          <= rx_next;
    ry          <= ry_next;
    rz          <= rz_next;
    scalar_out  <= scalar_next;
    saturated   <= sat_next;
    zero_vector <= zero_next;
  end

endmodule

### design/vau_front.sv
// ----------------------------------------------------------------------------
// Vector arithmetic front end
// Input registers, the shared bank of six multipliers, and the stage that
// forms sums, dot, cross and scale results and the sum of squares.
// ----------------------------------------------------------------------------
module vau_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [2:0]          cmd,
  input  logic signed [31:0]  ax,
  input  logic signed [31:0]  ay,
  input  logic signed [31:0]  az,
  input  logic signed [31:0]  bx,
  input  logic signed [31:0]  by,
  input  logic signed [31:0]  bz,
  input  logic signed [31:0]  factor,
  output logic                out_valid,
  output vau_pkg::side_t      side,
  output logic [63:0]         sumsq
);

  // Stage 0 registers.
  logic               v0;
  logic [2:0]         cmd0;
  logic signed [31:0] a0 [3];
  logic signed [31:0] b0 [3];
  logic signed [31:0] f0;

  // Stage 1 registers.
  logic               v1;
  logic [2:0]         cmd1;
  logic signed [31:0] a1 [3];
  logic signed [63:0] p1 [6];
  logic signed [31:0] ar1 [3];
  logic               asat1;

  // Stage 1 operands and add/subtract results.
  logic signed [31:0] opa [6];
  logic signed [31:0] opb [6];
  logic signed [32:0] sum33 [3];
  logic [32:0]        sres [3];

  // Stage 2 results.
  vau_pkg::side_t     side_next;
  logic signed [65:0] dot66;
  logic signed [65:0] dsh;
  logic signed [65:0] cr66 [3];
  logic [32:0]        cres [3];
  logic [32:0]        scres [3];

  // Capture the request.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
    cmd0  <= cmd;
    a0[0] <= ax;
    a0[1] <= ay;
    a0[2] <= az;
    b0[0] <= bx;
    b0[1] <= by;
    b0[2] <= bz;
    f0    <= factor;
  end

  // Multiplier operand selection by command.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      opa[i] = '0;
      opb[i] = '0;
    end
    case (cmd0)
      vau_pkg::CMD_DOT: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = a0[i];
          opb[i] = b0[i];
        end
      end
      vau_pkg::CMD_CROSS: begin
        opa[0] = a0[1]; opb[0] = b0[2];
        opa[1] = a0[2]; opb[1] = b0[1];
        opa[2] = a0[2]; opb[2] = b0[0];
        opa[3] = a0[0]; opb[3] = b0[2];
        opa[4] = a0[0]; opb[4] = b0[1];
        opa[5] = a0[1]; opb[5] = b0[0];
      end
      vau_pkg::CMD_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = a0[i];
          opb[i] = f0;
        end
      end
      vau_pkg::CMD_LEN, vau_pkg::CMD_NORM: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = a0[i];
          opb[i] = a0[i];
        end
      end
      default: begin
      end
    endcase
  end

  // Saturating add or subtract per component.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cmd0 == vau_pkg::CMD_SUB) begin
        sum33[i] = 33'(a0[i]) - 33'(b0[i]);
      end else begin
        sum33[i] = 33'(a0[i]) + 33'(b0[i]);
      end
      sres[i] = vau_pkg::sat32(66'(sum33[i]));
    end
  end

  // Multiply and register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    cmd1 <= cmd0;
    for (int i = 0; i < 3; i++) begin
      a1[i]  <= a0[i];
      ar1[i] <= sres[i][31:0];
    end
    for (int i = 0; i < 6; i++) begin
      p1[i] <= opa[i] * opb[i];
    end
    asat1 <= sres[0][32] | sres[1][32] | sres[2][32];
  end

  // Combine products into the command's early result.
  always_comb begin
    dot66 = 66'(p1[0]) + 66'(p1[1]) + 66'(p1[2]);
    dsh   = dot66 >>> 16;
    cr66[0] = (66'(p1[0]) - 66'(p1[1])) >>> 16;
    cr66[1] = (66'(p1[2]) - 66'(p1[3])) >>> 16;
    cr66[2] = (66'(p1[4]) - 66'(p1[5])) >>> 16;
    for (int i = 0; i < 3; i++) begin
      cres[i]  = vau_pkg::sat32(cr66[i]);
      scres[i] = vau_pkg::sat32(66'(p1[i]) >>> 16);
    end

    side_next        = '0;
    side_next.cmd    = cmd1;
    side_next.ax     = a1[0];
    side_next.ay     = a1[1];
    side_next.az     = a1[2];
    case (cmd1)
      vau_pkg::CMD_ADD, vau_pkg::CMD_SUB: begin
        side_next.rx  = ar1[0];
        side_next.ry  = ar1[1];
        side_next.rz  = ar1[2];
        side_next.sat = asat1;
      end
      vau_pkg::CMD_DOT: begin
        side_next.scalar = dsh[63:0];
      end
      vau_pkg::CMD_CROSS: begin
        side_next.rx  = cres[0][31:0];
        side_next.ry  = cres[1][31:0];
        side_next.rz  = cres[2][31:0];
        side_next.sat = cres[0][32] | cres[1][32] | cres[2][32];
      end
      vau_pkg::CMD_SCALE: begin
        side_next.rx  = scres[0][31:0];
        side_next.ry  = scres[1][31:0];
        side_next.rz  = scres[2][31:0];
        side_next.sat = scres[0][32] | scres[1][32] | scres[2][32];
      end
      default: begin
      end
    endcase
  end

  // Stage 2 registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
    side  <= side_next;
    sumsq <= 64'(p1[0]) + 64'(p1[1]) + 64'(p1[2]);
  end

endmodule

### design/vau_sqrt.sv
// ----------------------------------------------------------------------------
// Vector arithmetic square root pipeline
// Integer square root of a 64-bit sum of squares, four root bits per stage.
// ----------------------------------------------------------------------------
module vau_sqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [63:0]     sumsq,
  input  vau_pkg::side_t  in_side,
  output logic            out_valid,
  output logic [31:0]     root,
  output vau_pkg::side_t  out_side
);

  logic [vau_pkg::SQ_STAGES:0] vld;
  vau_pkg::sq_t                st [vau_pkg::SQ_STAGES+1];
  vau_pkg::side_t              sd [vau_pkg::SQ_STAGES+1];

  // Pipe entry.
  assign vld[0]     = in_valid;
  assign st[0].rem  = '0;
  assign st[0].root = '0;
  assign st[0].opnd = sumsq;
  assign sd[0]      = in_side;

  // Root stages.
  for (genvar k = 0; k < vau_pkg::SQ_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      st[k+1] <= vau_pkg::sqrt_stage(st[k]);
      sd[k+1] <= sd[k];
    end
  end

  assign out_valid = vld[vau_pkg::SQ_STAGES];
  assign root      = st[vau_pkg::SQ_STAGES].root;
  assign out_side  = sd[vau_pkg::SQ_STAGES];

endmodule

### design/vau_div.sv
// ----------------------------------------------------------------------------
// Vector arithmetic divider pipeline
// Divides each component magnitude, shifted up 16 bits, by the length.
// The quotient never exceeds 1.0, so 20 quotient bits cover it.
// ----------------------------------------------------------------------------
module vau_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [31:0]     in_root,
  input  vau_pkg::side_t  in_side,
  output logic            out_valid,
  output logic [31:0]     out_root,
  output logic [vau_pkg::QW-1:0] quo [3],
  output vau_pkg::side_t  out_side
);

  localparam int LowBits = vau_pkg::QW - 16;

  logic [vau_pkg::DV_STAGES:0] vld;
  vau_pkg::dv_t                st [vau_pkg::DV_STAGES+1][3];
  vau_pkg::side_t              sd [vau_pkg::DV_STAGES+1];
  logic [31:0]                 rt [vau_pkg::DV_STAGES+1];
  logic [31:0]                 mag [3];

  // Magnitudes of A.
  always_comb begin
    mag[0] = in_side.ax[31] ? 32'(-in_side.ax) : in_side.ax;
    mag[1] = in_side.ay[31] ? 32'(-in_side.ay) : in_side.ay;
    mag[2] = in_side.az[31] ? 32'(-in_side.az) : in_side.az;
  end

  // Divider entry: the high dividend bits start out as the remainder.
  assign vld[0] = in_valid;
  assign sd[0]  = in_side;
  assign rt[0]  = in_root;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      st[0][i].rem  = 32'(mag[i][31:LowBits]);
      st[0][i].bits = {mag[i][LowBits-1:0], 16'h0000};
      st[0][i].quo  = '0;
    end
  end

  // Division stages.
  for (genvar k = 0; k < vau_pkg::DV_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      for (int i = 0; i < 3; i++) begin
        st[k+1][i] <= vau_pkg::div_stage(st[k][i], rt[k]);
      end
      sd[k+1] <= sd[k];
      rt[k+1] <= rt[k];
    end
  end

  assign out_valid = vld[vau_pkg::DV_STAGES];
  assign out_root  = rt[vau_pkg::DV_STAGES];
  assign out_side  = sd[vau_pkg::DV_STAGES];
  assign quo[0]    = st[vau_pkg::DV_STAGES][0].quo;
  assign quo[1]    = st[vau_pkg::DV_STAGES][1].quo;
  assign quo[2]    = st[vau_pkg::DV_STAGES][2].quo;

endmodule
